// ----- rtl/bdpc_pkg.sv -----
// shared types, constants and codes for the button debounce press classifier
package bdpc_pkg;

  // width of the time arithmetic, differences wrap modulo 2**TimeBits
  localparam int unsigned TimeBits = 32;

  // register reset values
  localparam logic        RstReleasedLevel = 1'b1;
  localparam logic [15:0] RstDebounceMs    = 16'd15;
  localparam logic [15:0] RstShortMaxMs    = 16'd1000;
  localparam logic [15:0] RstLongMs        = 16'd2000;
  localparam logic [3:0]  RstEventEnable   = 4'hf;

  // event codes as seen on the result channel
  typedef enum logic [1:0] {
    EvPress   = 2'd0,
    EvShort   = 2'd1,
    EvRelease = 2'd2,
    EvLong    = 2'd3
  } evt_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgReleasedLevel = 3'd0,
    CfgDebounceMs    = 3'd1,
    CfgShortMaxMs    = 3'd2,
    CfgLongMs        = 3'd3,
    CfgEventEnable   = 3'd4
  } cfg_idx_e;

  // input beat
  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } in_t;

  // output beat
  typedef struct packed {
    logic [1:0] event_code;
    logic       last_event;
  } out_t;

  // configuration register set
  typedef struct packed {
    logic        released_level;
    logic [15:0] debounce_ms;
    logic [15:0] short_max_ms;
    logic [15:0] long_ms;
    logic [3:0]  event_enable;
  } cfg_t;

  // events produced by one sample, passed from classifier to emitter
  typedef struct packed {
    logic [1:0] count;
    evt_e       code0;
    evt_e       code1;
  } rec_t;

endpackage

// ----- rtl/bdpc_front.sv -----
// classifier: config registers, debounce and press state, event selection per sample
module bdpc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             accept_i,
  input  bdpc_pkg::in_t    in_data_i,
  output logic             push_o,
  output bdpc_pkg::rec_t   rec_o
);
  import bdpc_pkg::*;

  cfg_t                cfg_q;
  logic                raw_q, raw_d;
  logic                deb_q, deb_d;
  logic [TimeBits-1:0] deb_start_q, deb_start_d;
  logic                stable_q, stable_d;
  logic                hold_q, hold_d;
  logic [TimeBits-1:0] press_start_q, press_start_d;

  logic [TimeBits-1:0] now;
  logic [TimeBits-1:0] deb_el, press_el, hold_el;
  logic                settle, changed, ev_press, ev_short, ev_release, ev_long, hold_mid;
  rec_t                rec;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.released_level <= RstReleasedLevel;
      cfg_q.debounce_ms    <= RstDebounceMs;
      cfg_q.short_max_ms   <= RstShortMaxMs;
      cfg_q.long_ms        <= RstLongMs;
      cfg_q.event_enable   <= RstEventEnable;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgReleasedLevel: cfg_q.released_level <= cfg_wdata_i[0];
        CfgDebounceMs:    cfg_q.debounce_ms    <= cfg_wdata_i;
        CfgShortMaxMs:    cfg_q.short_max_ms   <= cfg_wdata_i;
        CfgLongMs:        cfg_q.long_ms        <= cfg_wdata_i;
        CfgEventEnable:   cfg_q.event_enable   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign now = in_data_i.now_ms[TimeBits-1:0];

  // debounce: a level change restarts the timer
  always_comb begin
    raw_d       = in_data_i.pin_level;
    deb_d       = deb_q;
    deb_start_d = deb_start_q;
    if (in_data_i.pin_level != raw_q) begin
      deb_d       = 1'b1;
      deb_start_d = now;
    end
    deb_el = now - deb_start_d;
    settle = deb_d && (deb_el >= TimeBits'(cfg_q.debounce_ms));
    if (settle) begin
      deb_d = 1'b0;
    end
    stable_d = settle ? in_data_i.pin_level : stable_q;
  end

  // press classification against the accepted level
  always_comb begin
    changed    = stable_d != stable_q;
    ev_press   = changed && (stable_d != cfg_q.released_level);
    ev_release = changed && !ev_press;
    press_el   = now - press_start_q;
    ev_short   = ev_release && (press_el <= TimeBits'(cfg_q.short_max_ms));
    hold_el    = ev_press ? '0 : press_el;
    hold_mid   = ev_press ? 1'b1 : (ev_release ? 1'b0 : hold_q);
    ev_long    = hold_mid && (hold_el >= TimeBits'(cfg_q.long_ms));
    hold_d     = hold_mid && !ev_long;
    press_start_d = ev_press ? now : press_start_q;
  end

  // pack enabled events in order: press, short, release, long
  always_comb begin
    rec.count = 2'd0;
    rec.code0 = EvPress;
    rec.code1 = EvPress;
    if (ev_press && cfg_q.event_enable[EvPress]) begin
      rec.code0 = EvPress;
      rec.count = 2'd1;
    end
    if (ev_short && cfg_q.event_enable[EvShort]) begin
      rec.code0 = EvShort;
      rec.count = 2'd1;
    end
    if (ev_release && cfg_q.event_enable[EvRelease]) begin
      if (rec.count == 2'd0) begin
        rec.code0 = EvRelease;
      end else begin
        rec.code1 = EvRelease;
      end
      rec.count = rec.count + 2'd1;
    end
    if (ev_long && cfg_q.event_enable[EvLong]) begin
      if (rec.count == 2'd0) begin
        rec.code0 = EvLong;
      end else begin
        rec.code1 = EvLong;
      end
      rec.count = rec.count + 2'd1;
    end
  end

  assign rec_o  = rec;
  assign push_o = accept_i && (rec.count != 2'd0);

  // state update on each accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q         <= RstReleasedLevel;
      deb_q         <= 1'b0;
      deb_start_q   <= '0;
      stable_q      <= RstReleasedLevel;
      hold_q        <= 1'b0;
      press_start_q <= '0;
    end else if (accept_i) begin
      raw_q         <= raw_d;
      deb_q         <= deb_d;
      deb_start_q   <= deb_start_d;
      stable_q      <= stable_d;
      hold_q        <= hold_d;
      press_start_q <= press_start_d;
    end
  end

  // a level that has settled is the latest raw level
  assert property (@(posedge clk_i) disable iff (!rst_ni) !deb_q |-> (stable_q == raw_q))
    else $error("settled level differs from raw level");
  // a release is never followed in the same sample by a long press
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ev_release && ev_long))
    else $error("release and long press from one sample");
  // a push never carries more than two events
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> (rec_o.count <= 2'd2))
    else $error("record holds more than two events");

endmodule

// ----- rtl/bdpc_queue.sv -----
// two-entry queue of event records between classifier and emitter
module bdpc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bdpc_pkg::rec_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output bdpc_pkg::rec_t head_o
);
  import bdpc_pkg::*;

  rec_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q == 2'd2;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = entry_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // fill count
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count out of range");
  // pointers stay apart by exactly the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/bdpc_back.sv -----
// emitter: walks each record one event per cycle into the output register while the receiver does not stall
module bdpc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  bdpc_pkg::rec_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bdpc_pkg::out_t out_data_o
);
  import bdpc_pkg::*;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic idx_q, idx_d;
  logic load, last;

  assign load = !out_valid_q || !out_stall_i;
  assign last = idx_q || (head_i.count == 2'd1);

  // next beat selection
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        out_d.event_code = idx_q ? head_i.code1 : head_i.code0;
        out_d.last_event = last;
        idx_d            = !last;
        pop_o            = last;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // second event of a record only follows a non-final first one
  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q |-> head_valid_i)
    else $error("record index set with empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      idx_q |-> (head_i.count == 2'd2))
    else $error("second event of single-event record");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !out_q.last_event) |-> idx_q)
    else $error("non-final beat shown without pending second event");

endmodule

// ----- rtl/button_debounce_press_classifier_top.sv -----
// top level of the button debounce and press classifier
//
// Input channel: in_valid_i / in_stall_o / in_data_i, one beat per pin sample
// carrying the raw level and the millisecond time. Output channel:
// out_valid_o / out_stall_i / out_data_o, one beat per event (press, short,
// release, long); last_event marks the final event of a sample. A sample
// causes zero, one or two events; one that causes none gives no beat.
// A beat moves at a rising edge with valid high and stall low.
// An event passes from the record queue into the output register; the second
// event of a sample follows the first. The classifier takes a sample
// every cycle while the two-entry record queue has room; the emitter gives
// one event per cycle while the receiver does not stall.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i);
// the user must write it only while idle, the block does not enforce this;
// indexes above four are ignored.
// Reset clears the queue and output register and loads register defaults;
// the raw and accepted levels start at the released level. When the
// receiver stalls, the shown event holds, the queue fills and then
// in_stall_o rises.
module button_debounce_press_classifier_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bdpc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bdpc_pkg::out_t out_data_o
);
  import bdpc_pkg::*;

  logic accept, push, full, pop, head_valid;
  rec_t rec, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // classifier
  bdpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .rec_o      (rec)
  );

  // record queue
  bdpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (rec),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  // event emitter
  bdpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- verif/button_debounce_press_classifier_top_tb.sv -----
// testbench for the button debounce and press classifier, self-checking against its own predictor
`timescale 1ns / 100ps

module button_debounce_press_classifier_top_tb;
  import bdpc_pkg::*;

  // quiet cycles allowed before the run is declared hung
  localparam int unsigned QuietLimit   = 2000;
  // cycles allowed for a sample that causes no event to leave the pipeline
  localparam int unsigned SettleCycles = 4;
  // an index past the last register, writes to it are dropped
  localparam logic [2:0]  CfgSpareIdx  = 3'(CfgEventEnable) + 3'd1;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;

  button_debounce_press_classifier_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of the registers
  logic        rel_lvl  = RstReleasedLevel;
  logic [15:0] deb_ms   = RstDebounceMs;
  logic [15:0] short_ms = RstShortMaxMs;
  logic [15:0] long_ms  = RstLongMs;
  logic [3:0]  ev_en    = RstEventEnable;

  // predictor copy of the classifier state
  logic        raw_lvl     = RstReleasedLevel;
  logic        bouncing    = 1'b0;
  logic [31:0] bounce_t0   = '0;
  logic        stable_lvl  = RstReleasedLevel;
  logic        prev_stable = RstReleasedLevel;
  logic        held        = 1'b0;
  logic [31:0] press_t0    = '0;

  out_t        ev_buf[$];
  out_t        evt_exp_q[$];

  int unsigned err_count    = 0;
  int unsigned sent_count   = 0;
  int unsigned quiet_cycles = 0;
  bit          calm         = 1'b0;
  logic [31:0] wall_ms      = '0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // queue one event of the current sample if enabled and there is room
  function automatic void note_event(input evt_e code);
    out_t ev;
    if (ev_en[code] && ev_buf.size() < 2) begin
      ev.event_code = code;
      ev.last_event = 1'b0;
      ev_buf.push_back(ev);
    end
  endfunction

  // work out the events one sample causes and append them to the expected queue
  function automatic void classify_sample(input in_t s);
    logic [31:0] dt;
    out_t        ev;
    int          i;
    ev_buf.delete();

    // level change restarts the debounce timer
    if (s.pin_level != raw_lvl) begin
      raw_lvl   = s.pin_level;
      bouncing  = 1'b1;
      bounce_t0 = s.now_ms;
    end
    dt = s.now_ms - bounce_t0;
    if (bouncing && dt >= {16'd0, deb_ms}) begin
      stable_lvl = raw_lvl;
      bouncing   = 1'b0;
    end

    // accepted level moved: press or release
    if (stable_lvl != prev_stable) begin
      if (stable_lvl != rel_lvl) begin
        note_event(EvPress);
        held     = 1'b1;
        press_t0 = s.now_ms;
      end else begin
        held = 1'b0;
        dt   = s.now_ms - press_t0;
        if (dt <= {16'd0, short_ms}) note_event(EvShort);
        note_event(EvRelease);
      end
      prev_stable = stable_lvl;
    end

    // long press fires once per hold
    dt = s.now_ms - press_t0;
    if (held && dt >= {16'd0, long_ms}) begin
      note_event(EvLong);
      held = 1'b0;
    end

    for (i = 0; i < ev_buf.size(); i++) begin
      ev            = ev_buf[i];
      ev.last_event = (i == ev_buf.size() - 1);
      evt_exp_q.push_back(ev);
    end
  endfunction

  // check result beats, then predict from sample beats taken at the same edge
  always @(posedge clk_i) begin : event_check
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (evt_exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected event %0d last %0d",
                                    out_data_o.event_code, out_data_o.last_event));
        end else begin
          want = evt_exp_q.pop_front();
          if (out_data_o.event_code !== want.event_code)
            report_mismatch($sformatf("event_code %0d, expected %0d",
                                      out_data_o.event_code, want.event_code));
          if (out_data_o.last_event !== want.last_event)
            report_mismatch($sformatf("last_event %0d, expected %0d (event %0d)",
                                      out_data_o.last_event, want.last_event,
                                      want.event_code));
        end
      end
      if (in_valid_i && !in_stall_o) classify_sample(in_data_i);
    end
  end

  // receiver stalls at random except in the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 28);
  end

  // hang detection: cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // send one sample beat, valid stays high afterwards until the next decision
  task automatic send_sample(input logic lvl, input logic [31:0] t);
    in_t beat;
    beat.pin_level = lvl;
    beat.now_ms    = t;
    while (!calm && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  // stop sending and wait for every expected event plus pipeline slack
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (evt_exp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgReleasedLevel: rel_lvl  = val[0];
      CfgDebounceMs:    deb_ms   = val;
      CfgShortMaxMs:    short_ms = val;
      CfgLongMs:        long_ms  = val;
      CfgEventEnable:   ev_en    = val[3:0];
      default: ;
    endcase
  endtask

  // full register set, plus a dropped write to a spare index
  task automatic load_config(input logic rel, input logic [15:0] deb, input logic [15:0] sh,
                             input logic [15:0] lg, input logic [3:0] en);
    write_reg(CfgReleasedLevel, {15'd0, rel});
    write_reg(CfgDebounceMs, deb);
    write_reg(CfgShortMaxMs, sh);
    write_reg(CfgLongMs, lg);
    write_reg(CfgEventEnable, {12'd0, en});
    write_reg(CfgSpareIdx, 16'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // released level flipped straight after reset: release with no press behind it
  task automatic test_release_before_press();
    load_config(1'b0, RstDebounceMs, RstShortMaxMs, RstLongMs, RstEventEnable);
    send_sample(1'b0, 32'd5);
    send_sample(1'b0, 32'd25);
    send_sample(1'b1, 32'd40);
    send_sample(1'b1, 32'd55);
    send_sample(1'b1, 32'd2055);
    drain();
  endtask

  // zero debounce, short and long: two events from one sample, and time wrap
  task automatic test_same_step_pairs();
    load_config(1'b1, 16'd0, 16'd0, 16'd0, RstEventEnable);
    send_sample(1'b0, 32'd100);
    send_sample(1'b1, 32'd100);
    send_sample(1'b0, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'h0000_0010);
    drain();
  endtask

  // all-ones timings, holds across the wrap point
  task automatic test_wide_settings();
    load_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, RstEventEnable);
    send_sample(1'b0, 32'hFFFF_0000);
    send_sample(1'b0, 32'hFFFF_FFFE);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'h0000_0000);
    send_sample(1'b1, 32'h0000_FFFF);
    send_sample(1'b0, 32'h0001_0000);
    send_sample(1'b0, 32'h0002_0000);
    send_sample(1'b0, 32'h0002_FFFF);
    send_sample(1'b1, 32'h8000_0000);
    send_sample(1'b1, 32'hFFFF_FFFF);
    drain();
  endtask

  // masked events still move the state
  task automatic test_disabled_events();
    load_config(1'b1, RstDebounceMs, RstShortMaxMs, RstLongMs, 4'h0);
    send_sample(1'b0, 32'd10);
    send_sample(1'b0, 32'd30);
    send_sample(1'b0, 32'd3000);
    send_sample(1'b1, 32'd3100);
    send_sample(1'b1, 32'd3120);
    drain();
    // short and long only
    load_config(1'b1, RstDebounceMs, RstShortMaxMs, RstLongMs, 4'hA);
    send_sample(1'b0, 32'd4000);
    send_sample(1'b0, 32'd4015);
    send_sample(1'b1, 32'd4100);
    send_sample(1'b1, 32'd4115);
    drain();
  endtask

  function automatic logic [15:0] pick_ms(input int unsigned typical);
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, typical));
    endcase
  endfunction

  // one press and release with contact bounce, hold aimed at the short and long edges
  task automatic press_episode();
    logic        down;
    logic [31:0] t_acc, rel_t, target, span;
    int unsigned k, i;
    down = ~rel_lvl;
    // bounce at one timestamp never settles unless debounce is zero
    repeat ($urandom_range(0, 2)) begin
      send_sample(down, wall_ms);
      send_sample(~down, wall_ms);
    end
    send_sample(down, wall_ms);
    wall_ms += 32'(deb_ms) + 32'($urandom_range(0, 1));
    send_sample(down, wall_ms);
    t_acc = wall_ms;
    case ($urandom_range(0, 6))
      0:       target = 32'(short_ms);
      1:       target = 32'(short_ms) + 32'd1;
      2:       target = 32'(long_ms);
      3:       target = 32'(long_ms) - 32'd1;
      default: target = 32'($urandom_range(0, 32'(long_ms) + 32'(long_ms) / 2 + 1));
    endcase
    rel_t = (target > 32'(deb_ms)) ? t_acc + target - 32'(deb_ms) : t_acc;
    span  = rel_t - t_acc;
    // samples during the hold
    k = $urandom_range(0, 3);
    for (i = 1; i <= k; i++)
      send_sample(down, t_acc + 32'((64'(span) * i) / (k + 1)));
    if ($urandom_range(0, 1) && 32'(long_ms) <= span)
      send_sample(down, t_acc + 32'(long_ms));
    // bounce on the way back
    repeat ($urandom_range(0, 2)) begin
      send_sample(~down, rel_t);
      send_sample(down, rel_t);
    end
    send_sample(~down, rel_t);
    wall_ms = rel_t + 32'(deb_ms);
    send_sample(~down, wall_ms);
    wall_ms += 32'($urandom_range(0, 50));
  endtask

  // random levels, some at arbitrary times
  task automatic line_noise();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 3) == 0) wall_ms = $urandom;
      else wall_ms += 32'($urandom_range(0, 32'(deb_ms) + 3));
      send_sample(1'($urandom), wall_ms);
    end
  endtask

  // several phases of random settings, mostly well-formed presses
  task automatic test_random_presses();
    int unsigned goal, phase_end, phase, pick;
    goal  = sent_count + 950;
    phase = 0;
    while (sent_count < goal) begin
      case (phase)
        0:       load_config(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, RstEventEnable);
        1:       load_config(1'b1, 16'd0, 16'd0, 16'd0, RstEventEnable);
        default: load_config(1'($urandom), pick_ms(40), pick_ms(400), pick_ms(800),
                             ($urandom_range(0, 2) == 0) ? 4'($urandom) : RstEventEnable);
      endcase
      calm    = (phase == 3);
      wall_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 5000))
                                             : 32'($urandom);
      phase_end = sent_count + 120;
      while (sent_count < phase_end && sent_count < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) press_episode();
        else line_noise();
      end
      drain();
      calm = 1'b0;
      phase++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_release_before_press();
    test_same_step_pairs();
    test_wide_settings();
    test_disabled_events();
    test_random_presses();
    repeat (8) @(posedge clk_i);
    if (evt_exp_q.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", evt_exp_q.size()));
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bdpc_pkg.sv
rtl/bdpc_front.sv
rtl/bdpc_queue.sv
rtl/bdpc_back.sv
rtl/button_debounce_press_classifier_top.sv
verif/button_debounce_press_classifier_top_tb.sv
